// File: src/irfd_pkg.sv
// Shared types, constants and lookup functions for the IR frame decoder.
// No dependencies; used by ir_frame_decoder_multitap, irfd_keypress_checker and the testbench.
package irfd_pkg;

   localparam int FRAME_BITS_DEF = 49;
   localparam int CODE_BITS      = 49;
   localparam int NUM_KEYS       = 12;

   // Key codes as reported on the result channel
   localparam logic [3:0] KEY_DIGITS  = 4'd10;
   localparam logic [3:0] KEY_ENTER   = 4'd10;
   localparam logic [3:0] KEY_DELETE  = 4'd11;
   localparam logic [3:0] KEY_UNKNOWN = 4'd12;

   // Actions
   localparam logic [2:0] ACT_IGNORE  = 3'd0;
   localparam logic [2:0] ACT_NEW     = 3'd1;
   localparam logic [2:0] ACT_REPLACE = 3'd2;
   localparam logic [2:0] ACT_DELETE  = 3'd3;
   localparam logic [2:0] ACT_ENTER   = 3'd4;
   localparam logic [2:0] ACT_UNKNOWN = 3'd5;

   // Register indexes (byte address is four times the index)
   localparam logic [2:0] REG_MS_TICKS     = 3'd0;
   localparam logic [2:0] REG_GAP_UNITS    = 3'd1;
   localparam logic [2:0] REG_ONE_UNITS    = 3'd2;
   localparam logic [2:0] REG_NEW_LETTER   = 3'd3;
   localparam logic [2:0] REG_REPEAT_GUARD = 3'd4;

   localparam logic [23:0] MS_TICKS_RST     = 24'd80000;
   localparam logic [7:0]  GAP_UNITS_RST    = 8'd10;
   localparam logic [7:0]  ONE_UNITS_RST    = 8'd1;
   localparam logic [31:0] NEW_LETTER_RST   = 32'd800000000;
   localparam logic [31:0] REPEAT_GUARD_RST = 32'd80000000;

   localparam logic [CODE_BITS-1:0] KEY_CODES [NUM_KEYS] = '{
      49'b1010000000000010000000001000000001001100010011001,
      49'b1010000000000010000000001000000000000100000001001,
      49'b1010000000000010000000001000000001000100010001001,
      49'b1010000000000010000000001000000000100100001001001,
      49'b1010000000000010000000001000000001100100011001001,
      49'b1010000000000010000000001000000000010100000101001,
      49'b1010000000000010000000001000000001010100010101001,
      49'b1010000000000010000000001000000000110100001101001,
      49'b1010000000000010000000001000000001110100011101001,
      49'b1010000000000010000000001000000000001100000011001,
      49'b1010000000000010000000001000000001110110011101101,
      49'b1010000000000010000000001000000000100110001001101
   };

   typedef struct packed {
      logic [23:0] edge_time;
      logic [31:0] coarse_time;
   } req_word_type;

   typedef struct packed {
      logic [2:0] action;
      logic [3:0] key_code;
      logic [7:0] character;
      logic       advance;
   } rsp_word_type;

   // Highest letter index on each key; special keys have one entry only.
   function automatic logic [1:0] letter_limit(input logic [3:0] key);
      logic [1:0] lim;
      case (key)
         4'd7, 4'd9: lim = 2'd3;
         4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: lim = 2'd2;
         default: lim = 2'd0;
      endcase
      return lim;
   endfunction

   // Multi-tap letters per digit key.
   function automatic logic [7:0] key_letter(input logic [3:0] key, input logic [1:0] idx);
      logic [7:0] ch;
      ch = 8'd0;
      case (key)
         4'd0: ch = (idx == 2'd0) ? 8'h20 : 8'h00;
         4'd1: begin
            case (idx)
               2'd0: ch = 8'h2C;
               2'd1: ch = 8'h2E;
               2'd2: ch = 8'h21;
               default: ch = 8'h00;
            endcase
         end
         4'd7: ch = 8'h70 + 8'(idx);
         4'd8: ch = (idx == 2'd3) ? 8'h00 : 8'h74 + 8'(idx);
         4'd9: ch = 8'h77 + 8'(idx);
         4'd2, 4'd3, 4'd4, 4'd5, 4'd6: begin
            // a..o run on in threes from key 2
            ch = (idx == 2'd3) ? 8'h00 : 8'h61 + 8'(3 * (key - 4'd2)) + 8'(idx);
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: src/ir_frame_decoder_multitap.sv
// Top level of the IR frame decoder with multi-tap text entry.
// Depends on irfd_pkg for the word types, key codes and letter tables.

// Each request word carries the down-counter and coarse timestamps of one IR edge. A word is
// taken into an input register and decoded from it: its interval is classed and, unless it is a
// gap that restarts the frame, shifted in; on the last bit of a frame, the frame is matched
// against the twelve key codes and run through the multi-tap logic into the result register. A
// new request word can be accepted in every cycle while the result register is free or being
// emptied; the rate is set by the single decode stage, which also holds all frame and key state.
// Only the edge that completes a frame gives a response word. The thresholds are products of
// unit size and unit counts, recomputed from the register values in the cycle of each write.
module ir_frame_decoder_multitap #(
   parameter int FRAME_BITS = irfd_pkg::FRAME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  irfd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output irfd_pkg::rsp_word_type rsp_word,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [4:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int CNT_W = $clog2(FRAME_BITS);

   // Configuration registers
   logic [23:0] ms_ticks_ff, ms_ticks_in;
   logic [7:0]  gap_units_ff, gap_units_in;
   logic [7:0]  one_units_ff, one_units_in;
   logic [31:0] new_letter_ff, new_letter_in;
   logic [31:0] repeat_guard_ff, repeat_guard_in;
   logic [31:0] gap_thr_ff, gap_thr_in;
   logic [31:0] one_thr_ff, one_thr_in;
   logic [23:0] unit_in;
   logic        csr_write;
   logic [2:0]  csr_index;

   // Pipeline
   logic                   in_valid_ff;
   irfd_pkg::req_word_type in_word_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   irfd_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic                   advance_stage;
   logic                   fire;

   // Decoder state
   logic [FRAME_BITS-1:0] bit_shift_ff, bit_shift_in;
   logic [CNT_W-1:0]      bit_count_ff, bit_count_in;
   logic [23:0]           prev_edge_ff, prev_edge_in;
   logic [FRAME_BITS-1:0] last_frame_ff, last_frame_in;
   logic [31:0]           last_key_time_ff, last_key_time_in;
   logic [1:0]            letter_index_ff, letter_index_in;
   logic [3:0]            key_row_ff, key_row_in;
   logic [1:0]            letter_limit_ff, letter_limit_in;
   logic                  entry_open_ff, entry_open_in;

   // Decode signals
   logic [23:0]           delta;
   logic                  is_gap;
   logic                  one_bit;
   logic [FRAME_BITS-1:0] frame;
   logic                  frame_done;
   logic [3:0]            key;
   logic [31:0]           pause;
   logic                  is_long;
   logic                  is_medium;
   logic [1:0]            next_index;

   // ---------------------------------------------------------------- configuration
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[4:2];
   assign pready    = 1'b1;

   always_comb begin
      ms_ticks_in     = ms_ticks_ff;
      gap_units_in    = gap_units_ff;
      one_units_in    = one_units_ff;
      new_letter_in   = new_letter_ff;
      repeat_guard_in = repeat_guard_ff;
      if (csr_write) begin
         case (csr_index)
            irfd_pkg::REG_MS_TICKS:     ms_ticks_in     = pwdata[23:0];
            irfd_pkg::REG_GAP_UNITS:    gap_units_in    = pwdata[7:0];
            irfd_pkg::REG_ONE_UNITS:    one_units_in    = pwdata[7:0];
            irfd_pkg::REG_NEW_LETTER:   new_letter_in   = pwdata;
            irfd_pkg::REG_REPEAT_GUARD: repeat_guard_in = pwdata;
            default: ;
         endcase
      end
      // A unit size of zero counts as one.
      unit_in    = (ms_ticks_in == 24'd0) ? 24'd1 : ms_ticks_in;
      // units >= n holds exactly when the interval is at least n whole units.
      gap_thr_in = 32'(gap_units_in) * 32'(unit_in);
      one_thr_in = 32'(one_units_in) * 32'(unit_in);
   end

   always_comb begin
      case (csr_index)
         irfd_pkg::REG_MS_TICKS:     prdata = {8'd0, ms_ticks_ff};
         irfd_pkg::REG_GAP_UNITS:    prdata = {24'd0, gap_units_ff};
         irfd_pkg::REG_ONE_UNITS:    prdata = {24'd0, one_units_ff};
         irfd_pkg::REG_NEW_LETTER:   prdata = new_letter_ff;
         irfd_pkg::REG_REPEAT_GUARD: prdata = repeat_guard_ff;
         default:                    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ticks_ff     <= irfd_pkg::MS_TICKS_RST;
         gap_units_ff    <= irfd_pkg::GAP_UNITS_RST;
         one_units_ff    <= irfd_pkg::ONE_UNITS_RST;
         new_letter_ff   <= irfd_pkg::NEW_LETTER_RST;
         repeat_guard_ff <= irfd_pkg::REPEAT_GUARD_RST;
         gap_thr_ff      <= 32'(irfd_pkg::GAP_UNITS_RST) * 32'(irfd_pkg::MS_TICKS_RST);
         one_thr_ff      <= 32'(irfd_pkg::ONE_UNITS_RST) * 32'(irfd_pkg::MS_TICKS_RST);
      end else begin
         ms_ticks_ff     <= ms_ticks_in;
         gap_units_ff    <= gap_units_in;
         one_units_ff    <= one_units_in;
         new_letter_ff   <= new_letter_in;
         repeat_guard_ff <= repeat_guard_in;
         gap_thr_ff      <= gap_thr_in;
         one_thr_ff      <= one_thr_in;
      end
   end

   // ---------------------------------------------------------------- handshake
   // The decode stage moves on whenever the result register is free or being emptied.
   assign advance_stage = ~rsp_valid_ff | rsp_ready;
   assign fire          = in_valid_ff & advance_stage;
   assign req_ready     = ~in_valid_ff | advance_stage;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_word_ff <= req_word;
      end
   end

   // ---------------------------------------------------------------- decode
   always_comb begin
      delta   = prev_edge_ff - in_word_ff.edge_time;
      is_gap  = {8'd0, delta} >= gap_thr_ff;
      one_bit = {8'd0, delta} >= one_thr_ff;
      frame   = {bit_shift_ff[FRAME_BITS-2:0], one_bit};
      frame_done = ~is_gap & (bit_count_ff == CNT_W'(FRAME_BITS - 1));

      key = irfd_pkg::KEY_UNKNOWN;
      for (int k = irfd_pkg::NUM_KEYS - 1; k >= 0; k--) begin
         if (64'(frame) == 64'(irfd_pkg::KEY_CODES[k])) begin
            key = 4'(k);
         end
      end

      pause     = in_word_ff.coarse_time - last_key_time_ff;
      is_long   = pause >= new_letter_ff;
      is_medium = ~is_long & (pause >= repeat_guard_ff);
      next_index = letter_index_ff + 2'd1;
   end

   always_comb begin
      bit_shift_in     = bit_shift_ff;
      bit_count_in     = bit_count_ff;
      prev_edge_in     = prev_edge_ff;
      last_frame_in    = last_frame_ff;
      last_key_time_in = last_key_time_ff;
      letter_index_in  = letter_index_ff;
      key_row_in       = key_row_ff;
      letter_limit_in  = letter_limit_ff;
      entry_open_in    = entry_open_ff;
      rsp_word_in      = rsp_word_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ready;

      if (fire) begin
         prev_edge_in = in_word_ff.edge_time;
         if (is_gap) begin
            bit_shift_in = '0;
            bit_count_in = '0;
         end else if (!frame_done) begin
            bit_shift_in = frame;
            bit_count_in = CNT_W'(bit_count_ff + 1'b1);
         end else begin
            bit_shift_in     = '0;
            bit_count_in     = '0;
            last_key_time_in = in_word_ff.coarse_time;
            rsp_valid_in     = 1'b1;
            rsp_word_in.action    = irfd_pkg::ACT_IGNORE;
            rsp_word_in.key_code  = key;
            rsp_word_in.character = 8'd0;
            rsp_word_in.advance   = 1'b0;

            if (frame != last_frame_ff || key >= irfd_pkg::KEY_DIGITS || is_long) begin
               rsp_word_in.advance = (key < irfd_pkg::KEY_DIGITS) & entry_open_ff;
               key_row_in      = key;
               letter_index_in = 2'd0;
               if (key != irfd_pkg::KEY_UNKNOWN) begin
                  letter_limit_in = irfd_pkg::letter_limit(key);
               end
               if (key < irfd_pkg::KEY_DIGITS) begin
                  rsp_word_in.action    = irfd_pkg::ACT_NEW;
                  rsp_word_in.character = irfd_pkg::key_letter(key, 2'd0);
               end else if (key == irfd_pkg::KEY_ENTER) begin
                  rsp_word_in.action = irfd_pkg::ACT_ENTER;
               end else if (key == irfd_pkg::KEY_DELETE) begin
                  rsp_word_in.action = irfd_pkg::ACT_DELETE;
               end else begin
                  rsp_word_in.action = irfd_pkg::ACT_UNKNOWN;
               end
               // Enter closes the entry, delete leaves it as it was.
               if (key == irfd_pkg::KEY_ENTER) begin
                  entry_open_in = 1'b0;
               end else if (key != irfd_pkg::KEY_DELETE) begin
                  entry_open_in = 1'b1;
               end
               last_frame_in = frame;
            end else if (is_medium && letter_index_ff < letter_limit_ff) begin
               letter_index_in = next_index;
               if (key_row_ff < irfd_pkg::KEY_DIGITS) begin
                  rsp_word_in.action    = irfd_pkg::ACT_REPLACE;
                  rsp_word_in.character = irfd_pkg::key_letter(key_row_ff, next_index);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         bit_shift_ff     <= '0;
         bit_count_ff     <= '0;
         prev_edge_ff     <= '0;
         last_frame_ff    <= '0;
         last_key_time_ff <= '0;
         letter_index_ff  <= '0;
         key_row_ff       <= '0;
         letter_limit_ff  <= '0;
         entry_open_ff    <= 1'b0;
      end else begin
         rsp_valid_ff     <= rsp_valid_in;
         bit_shift_ff     <= bit_shift_in;
         bit_count_ff     <= bit_count_in;
         prev_edge_ff     <= prev_edge_in;
         last_frame_ff    <= last_frame_in;
         last_key_time_ff <= last_key_time_in;
         letter_index_ff  <= letter_index_in;
         key_row_ff       <= key_row_in;
         letter_limit_ff  <= letter_limit_in;
         entry_open_ff    <= entry_open_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   // ---------------------------------------------------------------- assertions
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= CNT_W'(FRAME_BITS - 1))
      else $error("bit count has run past the frame length");

   a_index_limit: assert property (@(posedge clock) disable iff (reset)
      letter_index_ff <= letter_limit_ff)
      else $error("letter index beyond the key's last letter");

   a_gap_threshold: assert property (@(posedge clock) disable iff (reset)
      gap_thr_ff == 32'(gap_units_ff) * 32'((ms_ticks_ff == 24'd0) ? 24'd1 : ms_ticks_ff))
      else $error("gap threshold out of step with its registers");

   a_letter_on_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_word_ff.action == irfd_pkg::ACT_NEW ||
                       rsp_word_ff.action == irfd_pkg::ACT_REPLACE)
      |-> rsp_word_ff.key_code < irfd_pkg::KEY_DIGITS)
      else $error("character placed for a key that is not a digit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("pending response word was overwritten");

endmodule

// File: verif/irfd_keypress_checker.sv
// Checker for the IR frame decoder: predicts the key press result words from the
// accepted edge words and compares them with what comes out. Depends on irfd_pkg.
module irfd_keypress_checker #(
   parameter int FRAME_BITS = irfd_pkg::FRAME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  irfd_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  irfd_pkg::rsp_word_type rsp_word,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [4:0]             paddr,
   input  logic [31:0]            pwdata,
   input  logic                   pready,
   output int                     mismatches,
   output int                     keys_waiting
);
   import irfd_pkg::*;

   localparam logic [7:0] TAP_CHARS [10][4] = '{
      '{" ", 8'h00, 8'h00, 8'h00},
      '{",", ".", "!", 8'h00},
      '{"a", "b", "c", 8'h00},
      '{"d", "e", "f", 8'h00},
      '{"g", "h", "i", 8'h00},
      '{"j", "k", "l", 8'h00},
      '{"m", "n", "o", 8'h00},
      '{"p", "q", "r", "s"},
      '{"t", "u", "v", 8'h00},
      '{"w", "x", "y", "z"}
   };
   localparam logic [1:0] TAP_LAST [NUM_KEYS] = '{
      2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd0, 2'd0
   };

   logic [23:0] unit_ticks;
   logic [7:0]  gap_limit;
   logic [7:0]  one_limit;
   logic [31:0] new_char_pause;
   logic [31:0] repeat_pause;

   logic [FRAME_BITS-1:0] shift_bits;
   int unsigned           bits_in;
   logic [23:0]           prev_time;
   logic [FRAME_BITS-1:0] last_code;
   logic [31:0]           last_press;
   logic [1:0]            tap_idx;
   logic [1:0]            tap_max;
   logic [3:0]            row;
   logic                  text_open;

   rsp_word_type expected_keys [$];

   initial begin
      mismatches = 0;
      keys_waiting = 0;
   end

   function automatic logic [3:0] match_key(input logic [FRAME_BITS-1:0] frame);
      logic [3:0] k;
      k = KEY_UNKNOWN;
      // Walk downwards so that the lowest matching index wins.
      for (int n = NUM_KEYS - 1; n >= 0; n--) begin
         if (64'(frame) == 64'(KEY_CODES[n])) k = 4'(n);
      end
      return k;
   endfunction

   task automatic take_config(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_MS_TICKS:     unit_ticks = value[23:0];
         REG_GAP_UNITS:    gap_limit = value[7:0];
         REG_ONE_UNITS:    one_limit = value[7:0];
         REG_NEW_LETTER:   new_char_pause = value;
         REG_REPEAT_GUARD: repeat_pause = value;
         default: ;
      endcase
   endtask

   task automatic decode_ir_edge(input req_word_type w);
      logic [23:0]           delta;
      logic [23:0]           unit;
      logic [23:0]           units;
      logic [FRAME_BITS-1:0] frame;
      logic [3:0]            key;
      logic [31:0]           pause;
      logic                  is_long;
      logic                  is_medium;
      rsp_word_type          res;
      // The interval wraps with the 24-bit down-counter.
      delta = prev_time - w.edge_time;
      unit = (unit_ticks == 24'd0) ? 24'd1 : unit_ticks;
      units = delta / unit;
      prev_time = w.edge_time;
      if (units >= 24'(gap_limit)) begin
         shift_bits = '0;
         bits_in = 0;
      end else begin
         shift_bits = {shift_bits[FRAME_BITS-2:0], units >= 24'(one_limit)};
         bits_in++;
         if (bits_in >= FRAME_BITS) begin
            frame = shift_bits;
            shift_bits = '0;
            bits_in = 0;
            key = match_key(frame);
            pause = w.coarse_time - last_press;
            last_press = w.coarse_time;
            is_long = pause >= new_char_pause;
            is_medium = !is_long && pause >= repeat_pause;
            res = '0;
            res.key_code = key;
            res.action = ACT_IGNORE;
            if (frame != last_code || key >= KEY_DIGITS || is_long) begin
               res.advance = (key < KEY_DIGITS) && text_open;
               row = key;
               tap_idx = 2'd0;
               if (key != KEY_UNKNOWN) tap_max = TAP_LAST[key];
               if (key < KEY_DIGITS) begin
                  res.action = ACT_NEW;
                  res.character = TAP_CHARS[key][0];
               end else if (key == KEY_ENTER) begin
                  res.action = ACT_ENTER;
                  text_open = 1'b0;
               end else if (key == KEY_DELETE) begin
                  res.action = ACT_DELETE;
               end else begin
                  res.action = ACT_UNKNOWN;
               end
               // Delete leaves the open flag alone.
               if (key != KEY_ENTER && key != KEY_DELETE) text_open = 1'b1;
               last_code = frame;
            end else if (is_medium && tap_idx < tap_max) begin
               tap_idx++;
               if (row < KEY_DIGITS) begin
                  res.action = ACT_REPLACE;
                  res.character = TAP_CHARS[row][tap_idx];
               end
            end
            expected_keys.push_back(res);
         end
      end
   endtask

   task automatic compare_key(input rsp_word_type got);
      rsp_word_type want;
      if (expected_keys.size() == 0) begin
         $error("unexpected result word: action %0d key_code %0d character %0d advance %0d",
                got.action, got.key_code, got.character, got.advance);
         mismatches++;
      end else begin
         want = expected_keys.pop_front();
         if (got.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, got.action);
            mismatches++;
         end
         if (got.key_code !== want.key_code) begin
            $error("key_code: expected %0d, got %0d", want.key_code, got.key_code);
            mismatches++;
         end
         if (got.character !== want.character) begin
            $error("character: expected %0d, got %0d", want.character, got.character);
            mismatches++;
         end
         if (got.advance !== want.advance) begin
            $error("advance: expected %0d, got %0d", want.advance, got.advance);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         unit_ticks = MS_TICKS_RST;
         gap_limit = GAP_UNITS_RST;
         one_limit = ONE_UNITS_RST;
         new_char_pause = NEW_LETTER_RST;
         repeat_pause = REPEAT_GUARD_RST;
         shift_bits = '0;
         bits_in = 0;
         prev_time = '0;
         last_code = '0;
         last_press = '0;
         tap_idx = '0;
         tap_max = '0;
         row = '0;
         text_open = 1'b0;
         expected_keys.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_key(rsp_word);
         if (req_valid && req_ready) decode_ir_edge(req_word);
         if (psel && penable && pwrite && pready) take_config(paddr[4:2], pwdata);
      end
      keys_waiting = expected_keys.size();
   end

endmodule

// File: verif/ir_frame_decoder_multitap_tb.sv
// Testbench top for ir_frame_decoder_multitap: drives IR edge words and register
// writes, and takes its verdict from irfd_keypress_checker. Depends on irfd_pkg.
module ir_frame_decoder_multitap_tb;
   import irfd_pkg::*;

   localparam int              LIMIT        = 1000000;
   localparam int              TOTAL_ITEMS  = 1950;
   localparam int              PHASES       = 9;
   localparam longint unsigned MAX_SPAN     = 64'hFFFFFF;
   localparam longint unsigned MAX_PAUSE    = 64'hFFFFFFFF;

   typedef enum logic [1:0] {PAUSE_SHORT, PAUSE_MEDIUM, PAUSE_LONG} pause_kind_e;
   typedef enum logic [1:0] {SPAN_ZERO, SPAN_ONE, SPAN_GAP} span_kind_e;

   localparam int          SCRIPT_KEY [16] = '{2, 2, 2, 2, 2, 7, 7, 7, 7, 7, 7, 10, 11, 1, 0, 3};
   localparam pause_kind_e SCRIPT_PAUSE [16] = '{
      PAUSE_LONG, PAUSE_MEDIUM, PAUSE_MEDIUM, PAUSE_MEDIUM, PAUSE_SHORT,
      PAUSE_MEDIUM, PAUSE_MEDIUM, PAUSE_MEDIUM, PAUSE_MEDIUM, PAUSE_MEDIUM, PAUSE_LONG,
      PAUSE_SHORT, PAUSE_MEDIUM, PAUSE_SHORT, PAUSE_LONG, PAUSE_MEDIUM
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [4:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   int mismatches;
   int keys_waiting;
   int cycle_count = 0;

   // Stimulus side copy of the registers, used only to aim the intervals and pauses.
   logic [23:0] cfg_ms = MS_TICKS_RST;
   logic [7:0]  cfg_gap = GAP_UNITS_RST;
   logic [7:0]  cfg_one = ONE_UNITS_RST;
   logic [31:0] cfg_newl = NEW_LETTER_RST;
   logic [31:0] cfg_guard = REPEAT_GUARD_RST;

   logic [23:0] edge_prev = '0;
   logic [31:0] press_coarse = '0;
   int          prev_key = -1;
   int          items_sent = 0;
   logic        no_idle = 1'b0;
   logic        flood = 1'b0;
   logic        hold_request = 1'b0;

   always #5 clock = ~clock;

   ir_frame_decoder_multitap dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   irfd_keypress_checker watch (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatches(mismatches), .keys_waiting(keys_waiting)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("ir_frame_decoder_multitap_tb: FAIL");
         $finish;
      end
   end

   function automatic int idle_len();
      return ($urandom_range(99, 0) < 88) ? $urandom_range(3, 1) : $urandom_range(60, 8);
   endfunction

   // Picks a value in [lo, hi], landing on either end now and then.
   function automatic longint unsigned pick_in(input longint unsigned lo,
                                               input longint unsigned hi);
      int sel;
      sel = $urandom_range(99, 0);
      if (sel < 15) return lo;
      if (sel < 30) return hi;
      return $urandom_range(32'(hi), 32'(lo));
   endfunction

   function automatic logic [23:0] pick_delta(input span_kind_e kind);
      longint unsigned unit;
      longint unsigned one_lo;
      longint unsigned gap_lo;
      longint unsigned hi;
      unit = (cfg_ms == 24'd0) ? 1 : cfg_ms;
      one_lo = unit * cfg_one;
      gap_lo = unit * cfg_gap;
      if (kind == SPAN_GAP) begin
         if (gap_lo <= MAX_SPAN) return 24'(pick_in(gap_lo, MAX_SPAN));
         return 24'(pick_in(0, MAX_SPAN));
      end
      if (kind == SPAN_ONE) begin
         hi = (gap_lo - 1 < MAX_SPAN) ? gap_lo - 1 : MAX_SPAN;
         if (one_lo <= hi) return 24'(pick_in(one_lo, hi));
      end
      // A zero has to stay below both thresholds; a one that cannot be made falls here.
      hi = ((one_lo < gap_lo) ? one_lo : gap_lo) - 1;
      if (hi > MAX_SPAN) hi = MAX_SPAN;
      return 24'(pick_in(0, hi));
   endfunction

   function automatic logic [31:0] pick_pause(input pause_kind_e pk);
      longint unsigned newl;
      longint unsigned guard;
      newl = cfg_newl;
      guard = cfg_guard;
      if (pk == PAUSE_MEDIUM && guard < newl) return 32'(pick_in(guard, newl - 1));
      if (pk == PAUSE_SHORT && guard > 0 && newl > 0)
         return 32'(pick_in(0, ((guard < newl) ? guard : newl) - 1));
      if (pk != PAUSE_SHORT) return 32'(pick_in(newl, MAX_PAUSE));
      return $urandom;
   endfunction

   task automatic push_edge(input logic [23:0] et, input logic [31:0] ct);
      int gap;
      gap = (flood || no_idle || $urandom_range(1, 0) == 0) ? 0 : idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= '{edge_time: et, coarse_time: ct};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      edge_prev = et;
      items_sent++;
   endtask

   // A restart edge, then nbits bits of the code, most significant first.
   task automatic send_frame(input logic [CODE_BITS-1:0] code, input pause_kind_e pk,
                             input int nbits);
      logic [31:0] final_coarse;
      push_edge(edge_prev - pick_delta(SPAN_GAP), $urandom);
      final_coarse = press_coarse + pick_pause(pk);
      for (int i = 0; i < nbits; i++) begin
         push_edge(edge_prev - pick_delta(code[CODE_BITS-1-i] ? SPAN_ONE : SPAN_ZERO),
                   (i == CODE_BITS - 1) ? final_coarse : $urandom);
      end
      if (nbits == CODE_BITS) press_coarse = final_coarse;
   endtask

   task automatic random_frame();
      int                   r;
      int                   k;
      int                   nbits;
      logic [CODE_BITS-1:0] code;
      pause_kind_e          pk;
      r = $urandom_range(99, 0);
      nbits = CODE_BITS;
      pk = pause_kind_e'($urandom_range(2, 0));
      if (r < 45 && prev_key >= 0) begin
         // Same key again, mostly inside the repeat window to walk its letters.
         k = prev_key;
         r = $urandom_range(99, 0);
         pk = (r < 70) ? PAUSE_MEDIUM : (r < 85) ? PAUSE_SHORT : PAUSE_LONG;
      end else if (r < 85) begin
         k = $urandom_range(NUM_KEYS - 1, 0);
      end else begin
         k = -1;
      end
      if (k >= 0) code = KEY_CODES[k];
      else if (r < 93) code = CODE_BITS'({$urandom, $urandom});
      else code = KEY_CODES[$urandom_range(NUM_KEYS - 1, 0)] ^
                  (CODE_BITS'(1) << $urandom_range(CODE_BITS - 1, 0));
      prev_key = k;
      if ($urandom_range(99, 0) < 8) nbits = $urandom_range(CODE_BITS - 1, 1);
      if ($urandom_range(99, 0) < 5) begin
         repeat ($urandom_range(4, 1)) push_edge(24'($urandom), $urandom);
      end
      if (!flood) no_idle = ($urandom_range(99, 0) < 15);
      send_frame(code, pk, nbits);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Edges that end no frame may still be in the pipe when the last word has come.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (keys_waiting == 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_config(input logic [23:0] ms, input logic [7:0] gap, input logic [7:0] one,
                             input logic [31:0] newl, input logic [31:0] guard);
      wait_idle();
      write_reg(REG_MS_TICKS, 32'(ms));
      write_reg(REG_GAP_UNITS, 32'(gap));
      write_reg(REG_ONE_UNITS, 32'(one));
      write_reg(REG_NEW_LETTER, newl);
      write_reg(REG_REPEAT_GUARD, guard);
      cfg_ms = ms;
      cfg_gap = gap;
      cfg_one = one;
      cfg_newl = newl;
      cfg_guard = guard;
   endtask

   initial begin : rsp_side
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold = 300;
            hold_request = 1'b0;
         end
         if (hold == 0 && !no_idle && $urandom_range(3, 0) == 0) hold = idle_len();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int          nframes;
      logic [7:0]  g;
      logic [31:0] nl;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Counter extremes first, then a scripted run through every action.
      push_edge(24'd0, 32'd0);
      push_edge(24'hFFFFFF, 32'hFFFFFFFF);
      for (int i = 0; i < 16; i++) send_frame(KEY_CODES[SCRIPT_KEY[i]], SCRIPT_PAUSE[i], CODE_BITS);
      send_frame(CODE_BITS'({$urandom, $urandom}), PAUSE_SHORT, CODE_BITS);
      send_frame(KEY_CODES[3], PAUSE_MEDIUM, CODE_BITS);
      send_frame(KEY_CODES[4], PAUSE_SHORT, 20);
      send_frame(KEY_CODES[4], PAUSE_LONG, CODE_BITS);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_config(24'd3, 8'd10, 8'd2, 32'd1000, 32'd100);
            1: set_config(24'd0, 8'd255, 8'd1, 32'hFFFFFFFF, 32'd0);
            2: set_config(24'hFFFFFF, 8'd1, 8'd1, 32'd0, 32'hFFFFFFFF);
            3: set_config(24'd65536, 8'd255, 8'd254, 32'd5000, 32'd4999);
            4: set_config(24'd1, 8'd1, 8'd255, 32'd1, 32'd0);
            PHASES - 1: set_config(MS_TICKS_RST, GAP_UNITS_RST, ONE_UNITS_RST,
                                   NEW_LETTER_RST, REPEAT_GUARD_RST);
            default: begin
               g = 8'($urandom_range(255, 2));
               nl = $urandom;
               set_config(24'($urandom_range(32'(MAX_SPAN) / g, 1)), g,
                          8'($urandom_range(g - 1, 1)), nl, $urandom_range(nl, 0));
            end
         endcase
         if (p == 0) begin
            // Hold the result side off while edges stream in back to back.
            flood = 1'b1;
            no_idle = 1'b0;
            hold_request = 1'b1;
            repeat (7) random_frame();
            flood = 1'b0;
         end
         // Each phase sends at least one frame and tops the running total up to its share.
         nframes = 0;
         while (items_sent < ((p + 1) * TOTAL_ITEMS) / PHASES || nframes == 0) begin
            random_frame();
            nframes++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      no_idle = 1'b0;
      wait (keys_waiting == 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && keys_waiting == 0) begin
         $display("ir_frame_decoder_multitap_tb: PASS");
      end else begin
         $display("ir_frame_decoder_multitap_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
src/irfd_pkg.sv
src/ir_frame_decoder_multitap.sv
verif/irfd_keypress_checker.sv
verif/ir_frame_decoder_multitap_tb.sv
